### sv/lzr_pkg.sv
// shared types and constants of the lzss ring decoder
package lzr_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int MATCH_MAX  = 18;
	localparam int CNT_W      = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = FIFO_AW + 1;

	localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_DEPTH - MATCH_MAX);
	localparam logic [7:0]         FILL_BYTE  = 8'h20;

	typedef logic [RING_AW-1:0] pos_t;
	typedef logic [RING_AW:0]   fill_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [FCNT_W-1:0]  fcnt_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		pos_t       rd_addr;
		logic       wr_en;
		logic [7:0] wr_data;
		logic       restart;
	} ring_req_t;

	typedef enum logic [2:0] {
		PH_FLAG  = 3'b001,
		PH_TOKEN = 3'b010,
		PH_MATCH = 3'b100
	} phase_t;

endpackage

### sv/lzr_stream_if.sv
// valid/ready stream channel
interface lzr_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/lzr_ring.sv
// history ring memory with fill tracking and write-to-read forwarding
module lzr_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  lzr_pkg::ring_req_t req,
	output logic [7:0]         rd_data
);

	logic [7:0]    mem [lzr_pkg::RING_DEPTH];
	logic [7:0]    mem_q;
	logic [7:0]    byp_data_q;
	logic          byp_q;
	logic          hit_q;
	lzr_pkg::pos_t wp_q;
	lzr_pkg::fill_t fill_q;
	lzr_pkg::pos_t rd_off;

	assign rd_off = req.rd_addr - lzr_pkg::RING_START;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wp_q] <= req.wr_data;
		end
		mem_q      <= mem[req.rd_addr];
		byp_q      <= req.wr_en && (req.rd_addr == wp_q);
		byp_data_q <= req.wr_data;
		hit_q      <= ({1'b0, rd_off} < fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= lzr_pkg::RING_START;
			fill_q <= '0;
		end else if (req.restart) begin
			wp_q   <= lzr_pkg::RING_START;
			fill_q <= '0;
		end else if (req.wr_en) begin
			wp_q <= wp_q + 1'b1;
			if (fill_q != lzr_pkg::fill_t'(lzr_pkg::RING_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// entries not written since restart read as space
	assign rd_data = byp_q ? byp_data_q : (hit_q ? mem_q : lzr_pkg::FILL_BYTE);

endmodule

### sv/lzr_out_fifo.sv
// result queue between the copy stage and the output channel
module lzr_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  lzr_pkg::out_item_t  push_item,
	lzr_stream_if.source        result,
	output lzr_pkg::fcnt_t      count
);

	lzr_pkg::out_item_t             buf_q [lzr_pkg::FIFO_DEPTH];
	logic [lzr_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [lzr_pkg::FIFO_AW-1:0]    rd_ptr_q;
	lzr_pkg::fcnt_t                 count_q;
	logic                           pop;

	assign pop          = result.valid && result.ready;
	assign result.valid = (count_q != '0);
	assign result.data  = buf_q[rd_ptr_q];
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push_valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/lzr_ctrl.sv
// token decoder and copy sequencer
module lzr_ctrl #(
	parameter int MATCH_BIAS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	lzr_stream_if.sink          stream,
	input  lzr_pkg::fcnt_t      fifo_count,
	output lzr_pkg::ring_req_t  ring_req,
	input  logic [7:0]          ring_data,
	output logic                push_valid,
	output lzr_pkg::out_item_t  push_item
);

	lzr_pkg::phase_t phase_q;
	logic [7:0]      flag_q;
	logic [3:0]      left_q;
	logic [7:0]      off_low_q;
	logic            copy_q;
	logic            copy_last_q;
	lzr_pkg::pos_t   rd_addr_q;
	lzr_pkg::cnt_t   remain_q;

	logic            valid_s1;
	logic            lit_s1;
	logic [7:0]      lit_byte_s1;
	logic            run_last_s1;
	logic            restart_s1;

	logic            accept;
	logic            issue;
	logic            emits;
	logic [7:0]      b;
	logic            last;
	lzr_pkg::cnt_t   len_sum;
	lzr_pkg::cnt_t   len;
	logic [7:0]      byte_s1;

	assign b    = stream.data.in_byte;
	assign last = stream.data.stream_last;

	assign stream.ready = !copy_q && !valid_s1
		&& (fifo_count != lzr_pkg::fcnt_t'(lzr_pkg::FIFO_DEPTH));
	assign accept = stream.valid && stream.ready;
	assign issue  = copy_q && ((fifo_count + lzr_pkg::fcnt_t'(valid_s1))
		< lzr_pkg::fcnt_t'(lzr_pkg::FIFO_DEPTH));

	assign len_sum = lzr_pkg::cnt_t'(b[3:0]) + lzr_pkg::cnt_t'(MATCH_BIAS + 1);
	assign len     = (len_sum > lzr_pkg::cnt_t'(lzr_pkg::MATCH_MAX))
		? lzr_pkg::cnt_t'(lzr_pkg::MATCH_MAX) : len_sum;

	assign emits = ((phase_q == lzr_pkg::PH_TOKEN) && flag_q[0])
		|| (phase_q == lzr_pkg::PH_MATCH);

	assign byte_s1 = lit_s1 ? lit_byte_s1 : ring_data;

	assign ring_req.rd_addr = rd_addr_q;
	assign ring_req.wr_en   = valid_s1;
	assign ring_req.wr_data = byte_s1;
	assign ring_req.restart = (valid_s1 && restart_s1) || (accept && last && !emits);

	assign push_valid         = valid_s1;
	assign push_item.out_byte = byte_s1;
	assign push_item.run_last = run_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lzr_pkg::PH_FLAG;
			flag_q      <= '0;
			left_q      <= '0;
			off_low_q   <= '0;
			copy_q      <= 1'b0;
			copy_last_q <= 1'b0;
			rd_addr_q   <= '0;
			remain_q    <= '0;
			valid_s1    <= 1'b0;
			lit_s1      <= 1'b0;
			lit_byte_s1 <= '0;
			run_last_s1 <= 1'b0;
			restart_s1  <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			if (issue) begin
				valid_s1    <= 1'b1;
				lit_s1      <= 1'b0;
				run_last_s1 <= (remain_q == lzr_pkg::cnt_t'(1));
				restart_s1  <= copy_last_q && (remain_q == lzr_pkg::cnt_t'(1));
				rd_addr_q   <= rd_addr_q + 1'b1;
				remain_q    <= remain_q - 1'b1;
				if (remain_q == lzr_pkg::cnt_t'(1)) begin
					copy_q <= 1'b0;
				end
			end
			if (accept) begin
				unique case (phase_q)
					lzr_pkg::PH_TOKEN: begin
						if (flag_q[0]) begin
							valid_s1    <= 1'b1;
							lit_s1      <= 1'b1;
							lit_byte_s1 <= b;
							run_last_s1 <= 1'b1;
							restart_s1  <= last;
							flag_q      <= flag_q >> 1;
							left_q      <= left_q - 1'b1;
							phase_q     <= (left_q == 4'd1) ? lzr_pkg::PH_FLAG
								: lzr_pkg::PH_TOKEN;
						end else begin
							off_low_q <= b;
							phase_q   <= lzr_pkg::PH_MATCH;
						end
					end
					lzr_pkg::PH_MATCH: begin
						rd_addr_q   <= {b[7:4], off_low_q};
						remain_q    <= len;
						copy_q      <= 1'b1;
						copy_last_q <= last;
						flag_q      <= flag_q >> 1;
						left_q      <= left_q - 1'b1;
						phase_q     <= (left_q == 4'd1) ? lzr_pkg::PH_FLAG
							: lzr_pkg::PH_TOKEN;
					end
					default: begin
						flag_q  <= b;
						left_q  <= 4'd8;
						phase_q <= lzr_pkg::PH_TOKEN;
					end
				endcase
				if (last) begin
					phase_q   <= lzr_pkg::PH_FLAG;
					flag_q    <= '0;
					left_q    <= '0;
					off_low_q <= '0;
				end
			end
		end
	end

endmodule

### sv/lzss_ring_decoder.sv
// lzss decoder top level with 4096-byte history ring
// Decodes an LZSS stream one compressed byte per transfer and delivers one
// decompressed byte per result transfer, with run_last marking the last byte
// caused by an input byte. The second byte of a match starts a copy of its
// length (3 to 18), and while results are taken at once the copy loop reads
// the ring one byte per cycle through a registered read and writes each
// copied byte straight back; no new input byte is taken while a copy or a
// decoded byte is in flight. A stalled result channel holds the input and
// the copy loop once the four-entry result queue is full.
// Entries not yet written since reset or since the last stream byte read as
// space; a fill count tracks them, so there is no clearing pass and no dead time.
module lzss_ring_decoder #(
	parameter int MATCH_BIAS = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	lzr_stream_if.sink   stream,
	lzr_stream_if.source result
);

	lzr_pkg::ring_req_t ring_req;
	logic [7:0]         ring_data;
	lzr_pkg::fcnt_t     fifo_count;
	logic               push_valid;
	lzr_pkg::out_item_t push_item;

	lzr_ctrl #(
		.MATCH_BIAS(MATCH_BIAS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.fifo_count(fifo_count),
		.ring_req  (ring_req),
		.ring_data (ring_data),
		.push_valid(push_valid),
		.push_item (push_item)
	);

	lzr_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ring_req),
		.rd_data(ring_data)
	);

	lzr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.result    (result),
		.count     (fifo_count)
	);

endmodule

### tb/testbench.sv
// testbench of the lzss ring decoder: streamed bytes checked against a local decoder
module testbench;

	localparam int BIAS = 2;

	// decodes accepted input bytes and holds the decoded bytes still due
	class lzss_checker;
		logic [7:0]             ring [lzr_pkg::RING_DEPTH];
		lzr_pkg::pos_t          wpos;
		logic [7:0]             flags;
		int unsigned            left;
		lzr_pkg::phase_t        phase;
		logic [7:0]             off_lo;
		lzr_pkg::out_item_t     due_bytes [$];
		int                     errors;
		int                     n_in;
		int                     n_out;
		int                     n_streams;

		function new();
			clear();
			errors = 0;
			n_in = 0;
			n_out = 0;
			n_streams = 0;
		endfunction

		function void clear();
			foreach (ring[i])
				ring[i] = lzr_pkg::FILL_BYTE;
			wpos   = lzr_pkg::RING_START;
			flags  = '0;
			left   = 0;
			phase  = lzr_pkg::PH_FLAG;
			off_lo = '0;
		endfunction

		function void take_flag();
			flags = flags >> 1;
			if (left > 0)
				left--;
			phase = (left == 0) ? lzr_pkg::PH_FLAG : lzr_pkg::PH_TOKEN;
		endfunction

		function void note_input(lzr_pkg::in_item_t it);
			logic [7:0]    bs [$];
			logic [7:0]    b;
			lzr_pkg::pos_t src;
			int            cnt;
			n_in++;
			case (phase)
				lzr_pkg::PH_TOKEN: begin
					if (flags[0]) begin
						ring[wpos] = it.in_byte;
						wpos++;
						bs.push_back(it.in_byte);
						take_flag();
					end else begin
						off_lo = it.in_byte;
						phase  = lzr_pkg::PH_MATCH;
					end
				end
				lzr_pkg::PH_MATCH: begin
					src = {it.in_byte[7:4], off_lo};
					cnt = int'(it.in_byte[3:0]) + BIAS + 1;
					if (cnt > lzr_pkg::MATCH_MAX)
						cnt = lzr_pkg::MATCH_MAX;
					for (int k = 0; k < cnt; k++) begin
						b = ring[src + lzr_pkg::pos_t'(k)];
						ring[wpos] = b;
						wpos++;
						bs.push_back(b);
					end
					take_flag();
				end
				default: begin
					flags = it.in_byte;
					left  = 8;
					phase = lzr_pkg::PH_TOKEN;
				end
			endcase
			foreach (bs[i])
				due_bytes.push_back('{out_byte: bs[i], run_last: (i == bs.size() - 1)});
			if (it.stream_last) begin
				n_streams++;
				clear();
			end
		endfunction

		function void check_result(lzr_pkg::out_item_t got);
			lzr_pkg::out_item_t want;
			n_out++;
			if (due_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result byte %h run_last %b", $time,
					got.out_byte, got.run_last);
			end else begin
				want = due_bytes.pop_front();
				if (got.out_byte !== want.out_byte) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h", $time,
						want.out_byte, got.out_byte);
				end
				if (got.run_last !== want.run_last) begin
					errors++;
					$display("%0t: run_last expected %b actual %b", $time,
						want.run_last, got.run_last);
				end
			end
		endfunction

		function int due_count();
			return due_bytes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lzr_stream_if #(.T(lzr_pkg::in_item_t))  stream_ch ();
	lzr_stream_if #(.T(lzr_pkg::out_item_t)) result_ch ();

	lzss_ring_decoder #(.MATCH_BIAS(BIAS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	lzss_checker sb = new();
	bit          idle_on;
	int          stall_left;
	int          n_sent;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// values at the falling edge are those that the next rising edge transfers
	always @(negedge clk) begin
		if (arst_n) begin
			if (stream_ch.valid && stream_ch.ready)
				sb.note_input(stream_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.data);
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 15);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			stream_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.data  <= '{in_byte: b, stream_last: fin};
		do
			@(negedge clk);
		while (!stream_ch.ready);
		@(posedge clk);
		n_sent++;
	endtask

	// well-formed stream with random content, ending whole or on a cut token
	task automatic send_stream();
		logic [7:0]    q [$];
		logic [7:0]    fl;
		logic [3:0]    code;
		lzr_pkg::pos_t wl;
		lzr_pkg::pos_t src;
		int            ntok;
		int            k;
		int            j;
		int            fidx;
		int            cut;
		int            cnt;
		wl   = sb.wpos;
		ntok = $urandom_range(1, 14);
		cut  = $urandom_range(0, 3);
		if (cut == 2)
			ntok = 8 * $urandom_range(1, 2);
		k = 0;
		j = 8;
		fidx = 0;
		while (k < ntok) begin
			fl = 8'($urandom);
			fidx = q.size();
			q.push_back(fl);
			for (j = 0; j < 8 && k < ntok; j++, k++) begin
				if (fl[j]) begin
					q.push_back(8'($urandom));
					wl++;
				end else begin
					case ($urandom_range(0, 3))
						0: src = lzr_pkg::pos_t'($urandom);
						1: src = wl - lzr_pkg::pos_t'($urandom_range(1, 18));
						2: src = $urandom_range(0, 1) ? '1 : '0;
						default: src = wl - lzr_pkg::pos_t'($urandom_range(1, 200));
					endcase
					code = 4'($urandom);
					q.push_back(src[7:0]);
					q.push_back({src[11:8], code});
					cnt = int'(code) + BIAS + 1;
					if (cnt > lzr_pkg::MATCH_MAX)
						cnt = lzr_pkg::MATCH_MAX;
					wl += lzr_pkg::pos_t'(cnt);
				end
			end
		end
		if (cut == 2) begin
			q.push_back(8'($urandom));
		end else if (cut == 3) begin
			if (j >= 8) begin
				fidx = q.size();
				q.push_back(8'($urandom));
				j = 0;
			end
			q[fidx][j] = 1'b0;
			q.push_back(8'($urandom));
		end
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	initial begin
		int  target;
		bit  paused;
		int  burst;
		clk = 1'b0;
		arst_n = 1'b0;
		stream_ch.valid = 1'b0;
		stream_ch.data  = '0;
		result_ch.ready = 1'b0;
		stall_left = 0;
		n_sent = 0;
		idle_on = 1'b1;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// literals at both extremes, a long overlapping copy, copies from the ring ends,
		// then a match cut short by the stream end
		send_byte(8'h03, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hf5, 1'b0);
		send_byte(8'h12, 1'b1);
		// final flag byte
		send_byte(8'ha5, 1'b1);
		// stream ending on a completed match, read of the cleared ring
		send_byte(8'h00, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b1);
		// stream ending on a literal
		send_byte(8'h01, 1'b0);
		send_byte(8'h5a, 1'b1);
		// the ring must read as spaces again
		send_byte(8'h00, 1'b0);
		send_byte(8'hee, 1'b0);
		send_byte(8'hf0, 1'b1);

		target = n_sent + 150;
		while (n_sent < target) begin
			idle_on = (target - n_sent > 30) && ($urandom_range(0, 3) != 0);
			if (!paused && n_sent > target - 85) begin
				stream_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.due_count() != 0)
					@(posedge clk);
				paused = 1'b1;
			end
			if ($urandom_range(0, 4) != 0) begin
				send_stream();
			end else begin
				burst = $urandom_range(1, 6);
				for (int i = 0; i < burst; i++)
					send_byte(8'($urandom),
						(i == burst - 1) ? ($urandom_range(0, 3) != 0)
							: ($urandom_range(0, 7) == 0));
			end
		end
		idle_on = 1'b0;
		stream_ch.valid <= 1'b0;

		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d compressed bytes in %0d closed streams,", sb.n_in,
			sb.n_streams);
		$display("%0d decoded bytes checked", sb.n_out);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
